// ----- design/acfb_pkg.sv -----
package acfb_pkg;

  localparam int unsigned MaxFrameBytes = 22;
  localparam int unsigned IdxW          = $clog2(MaxFrameBytes);

  localparam logic [IdxW-1:0] LastShort9  = IdxW'(8);
  localparam logic [IdxW-1:0] LastLong14  = IdxW'(13);
  localparam logic [IdxW-1:0] LastLong20  = IdxW'(19);
  localparam logic [IdxW-1:0] LastLong22  = IdxW'(21);
  localparam logic [IdxW-1:0] CkIdxFirst  = IdxW'(13);
  localparam logic [IdxW-1:0] TailStart   = IdxW'(14);

  localparam logic [7:0] HdrLong    = 8'hA6;
  localparam logic [7:0] HdrShort   = 8'hA5;
  localparam logic [7:0] HdrTail20  = 8'hB5;
  localparam logic [7:0] HdrTail22  = 8'hB7;
  localparam logic [4:0] ShortCtl   = 5'd12;

  localparam logic [4:0] BtnState   = 5'b00110;
  localparam logic [4:0] BtnVane    = 5'b00010;
  localparam logic [4:0] BtnSwingH  = 5'b00011;

  localparam logic [3:0] VaneSwing  = 4'hC;
  localparam logic [2:0] HorizAuto  = 3'h7;
  localparam logic [2:0] HorizMid   = 3'h0;

  typedef enum logic [1:0] {
    OpState  = 2'd0,
    OpToggle = 2'd1,
    OpExtra  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ModelLong14 = 2'd0,
    ModelShort9 = 2'd1,
    ModelLong20 = 2'd2,
    ModelLong22 = 2'd3
  } model_e;

  typedef enum logic [2:0] {
    ModeOff  = 3'd0,
    ModeCool = 3'd1,
    ModeAuto = 3'd2,
    ModeDry  = 3'd3,
    ModeHeat = 3'd4,
    ModeFan  = 3'd5
  } mode_e;

  typedef enum logic [0:0] {
    CfgTempMin = 1'b0,
    CfgTempMax = 1'b1
  } cfg_idx_e;

  localparam logic [2:0] SelMax    = 3'd5;
  localparam logic [2:0] SelVaneHi = 3'd3;
  localparam logic [2:0] SelHAuto  = 3'd4;

  typedef struct packed {
    logic [2:0] extra_sel;
    logic [2:0] toggle_sel;
    logic [5:0] feature_flags;
    logic [5:0] temperature;
    logic [1:0] fan;
    logic [2:0] mode;
    logic [1:0] model;
    logic [1:0] op;
  } req_t;

  typedef struct packed {
    logic [MaxFrameBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]               last;
    logic                          err;
  } frame_t;

  function automatic logic [2:0] mode_code(input logic [2:0] m);
    case (m)
      ModeAuto: mode_code = 3'd0;
      ModeDry:  mode_code = 3'd2;
      ModeHeat: mode_code = 3'd4;
      ModeFan:  mode_code = 3'd6;
      default:  mode_code = 3'd1;
    endcase
  endfunction

  function automatic logic [2:0] mode_code_short(input logic [2:0] m);
    case (m)
      ModeCool: mode_code_short = 3'd1;
      ModeDry:  mode_code_short = 3'd2;
      ModeHeat: mode_code_short = 3'd3;
      ModeFan:  mode_code_short = 3'd4;
      default:  mode_code_short = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] fan_level_code(input logic [1:0] f);
    case (f)
      2'd0:    fan_level_code = 3'd5;
      2'd1:    fan_level_code = 3'd3;
      2'd2:    fan_level_code = 3'd2;
      default: fan_level_code = 3'd1;
    endcase
  endfunction

  function automatic logic [4:0] toggle_button(input logic [2:0] s);
    case (s)
      3'd0:          toggle_button = 5'h05;
      3'd1:          toggle_button = 5'h02;
      3'd2, 3'd3:    toggle_button = 5'h08;
      3'd4:          toggle_button = 5'h07;
      default:       toggle_button = 5'h0B;
    endcase
  endfunction

  function automatic logic [3:0] vane_pos(input logic [1:0] s);
    case (s)
      2'd0:    vane_pos = 4'h1;
      2'd1:    vane_pos = 4'h2;
      2'd2:    vane_pos = 4'h3;
      default: vane_pos = 4'hA;
    endcase
  endfunction

endpackage

// ----- design/acfb_build.sv -----
module acfb_build (
  input  acfb_pkg::req_t   req_i,
  input  logic [5:0]       temp_min_i,
  input  logic [5:0]       temp_max_i,
  output acfb_pkg::frame_t frame_o
);
  import acfb_pkg::*;

  always_comb begin
    logic       fail;
    logic       power;
    logic [3:0] sv;
    logic [2:0] sh;
    logic [4:0] button;
    logic [2:0] mode_eff;
    logic [5:0] t_lo;
    logic [5:0] t_cl;
    logic [5:0] t_off;
    logic [3:0] tnib;
    logic [2:0] fc;
    logic [2:0] f2;

    fail   = 1'b0;
    power  = 1'b1;
    sv     = req_i.feature_flags[1] ? VaneSwing : 4'h0;
    sh     = HorizAuto;
    button = BtnState;

    unique case (req_i.op)
      OpState: begin
        if (req_i.mode == ModeOff || req_i.mode > ModeFan) fail = 1'b1;
      end
      OpToggle: begin
        if (req_i.toggle_sel > SelMax) begin
          fail = 1'b1;
        end else begin
          power  = (req_i.toggle_sel != 3'd0);
          button = toggle_button(req_i.toggle_sel);
        end
      end
      OpExtra: begin
        if (req_i.extra_sel > SelMax) begin
          fail = 1'b1;
        end else if (req_i.extra_sel <= SelVaneHi) begin
          sv     = vane_pos(req_i.extra_sel[1:0]);
          button = BtnVane;
        end else begin
          sh     = (req_i.extra_sel == SelHAuto) ? HorizAuto : HorizMid;
          button = BtnSwingH;
        end
      end
      default: fail = 1'b1;
    endcase

    mode_eff = (req_i.mode == ModeOff || req_i.mode > ModeFan) ? ModeCool : req_i.mode;

    t_lo  = (req_i.temperature < temp_min_i) ? temp_min_i : req_i.temperature;
    t_cl  = (t_lo > temp_max_i) ? temp_max_i : t_lo;
    t_off = t_cl - temp_min_i;
    tnib  = t_off[3:0];

    fc = fan_level_code(req_i.fan);
    f2 = (req_i.fan == 2'd0) ? 3'd0 : fc;

    frame_o       = '0;
    frame_o.err   = fail;
    if (!fail) begin
      if (req_i.model == ModelShort9) begin
        frame_o.last     = LastShort9;
        frame_o.bytes[0] = HdrShort;
        frame_o.bytes[1] = {tnib, 3'b000, power};
        frame_o.bytes[2] = {sv != 4'h0, sv != 4'h0, 6'h20};
        frame_o.bytes[4] = {2'b00, req_i.feature_flags[4], ShortCtl};
        frame_o.bytes[5] = {req_i.fan, 6'b0};
        frame_o.bytes[6] = {mode_code_short(mode_eff), 5'b0};
        frame_o.bytes[7] = {1'b0, req_i.feature_flags[5], 6'b0};
      end else begin
        frame_o.last      = LastLong14;
        frame_o.bytes[0]  = HdrLong;
        frame_o.bytes[1]  = {tnib, sv};
        frame_o.bytes[2]  = {sh, 5'b0};
        frame_o.bytes[3]  = {6'b0, req_i.feature_flags[4], 1'b0};
        frame_o.bytes[4]  = {1'b0, power, 6'b0};
        frame_o.bytes[5]  = {fc, 5'b0};
        frame_o.bytes[6]  = {req_i.feature_flags[3], req_i.feature_flags[2], 6'b0};
        frame_o.bytes[7]  = {mode_code(mode_eff), 5'b0};
        frame_o.bytes[8]  = {req_i.feature_flags[5], 7'b0};
        frame_o.bytes[12] = {3'b000, button};
        if (req_i.model == ModelLong20) begin
          frame_o.last      = LastLong20;
          frame_o.bytes[14] = HdrTail20;
          frame_o.bytes[16] = {f2, 5'b0};
        end else if (req_i.model == ModelLong22) begin
          frame_o.last      = LastLong22;
          frame_o.bytes[14] = HdrTail22;
          frame_o.bytes[16] = {f2[1:0], 6'b0};
        end
      end
    end
  end

endmodule

// ----- design/acfb_ser.sv -----
module acfb_ser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acfb_pkg::frame_t frame_i,
  input  logic             load_valid_i,
  output logic             load_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [7:0]       m_data_o,
  output logic             m_last_o,
  output logic             m_err_o
);
  import acfb_pkg::*;

  frame_t          frame_q;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic            at_last, is_ck, load, fire;
  logic [7:0]      byte_out;

  assign at_last      = (idx_q == frame_q.last);
  assign fire         = valid_q && m_ready_i;
  assign load_ready_o = !valid_q || (m_ready_i && at_last);
  assign load         = load_valid_i && load_ready_o;

  // checksum bytes come from the running sum
  assign is_ck    = !frame_q.err && (at_last || idx_q == CkIdxFirst);
  assign byte_out = is_ck ? sum_q : frame_q.bytes[idx_q];

  assign m_valid_o = valid_q;
  assign m_data_o  = byte_out;
  assign m_last_o  = at_last;
  assign m_err_o   = frame_q.err;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (fire) begin
      if (at_last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  assign sum_d = (idx_q == '0 || idx_q == TailStart) ? byte_out : sum_q + byte_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) frame_q <= frame_i;
    if (fire) sum_q <= sum_d;
  end

endmodule

// ----- design/ac_ir_frame_builder_top.sv -----
// channel   | direction | handshake                  | payload
// s_axis    | in        | s_axis_tvalid_i/tready_o   | tuser: op, tdata: request fields
// m_axis    | out       | m_axis_tvalid_o/tready_i   | tdata byte, tlast, tuser error
// cfg       | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A frame leaves one byte per cycle from the byte serializer while m_axis_tready_i
// is high; an error item is a single item. The next request is taken in the
// cycle the last byte of the current frame is taken, so frames run back to back.
// Reset clears the serializer and loads temp_min 16, temp_max 30.
// A low m_axis_tready_i holds the current byte and blocks new requests.
module ac_ir_frame_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // model[1:0], mode[4:2], fan[6:5], temperature[12:7],
  // feature_flags[18:13], toggle_sel[21:19], extra_sel[24:22], zero[31:25]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // frame_byte[7:0]
  output logic [7:0]  m_axis_tdata_o,
  // last_byte
  output logic        m_axis_tlast_o,
  // error[0]
  output logic        m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  import acfb_pkg::*;

  logic [5:0] temp_min_q;
  logic [5:0] temp_max_q;
  req_t       req;
  frame_t     frame;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_min_q <= 6'd16;
      temp_max_q <= 6'd30;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTempMin: temp_min_q <= cfg_data_i;
        CfgTempMax: temp_max_q <= cfg_data_i;
      endcase
    end
  end

  assign req.op            = s_axis_tuser_i;
  assign req.model         = s_axis_tdata_i[1:0];
  assign req.mode          = s_axis_tdata_i[4:2];
  assign req.fan           = s_axis_tdata_i[6:5];
  assign req.temperature   = s_axis_tdata_i[12:7];
  assign req.feature_flags = s_axis_tdata_i[18:13];
  assign req.toggle_sel    = s_axis_tdata_i[21:19];
  assign req.extra_sel     = s_axis_tdata_i[24:22];

  acfb_build u_build (
    .req_i      (req),
    .temp_min_i (temp_min_q),
    .temp_max_i (temp_max_q),
    .frame_o    (frame)
  );

  acfb_ser u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame),
    .load_valid_i (s_axis_tvalid_i),
    .load_ready_o (s_axis_tready_o),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o),
    .m_last_o     (m_axis_tlast_o),
    .m_err_o      (m_axis_tuser_o)
  );

`ifndef SYNTHESIS
  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == 8'h00))
    else $error("error item is not a single last item");

  a_frame_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("frame ended before its last byte");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> !(m_axis_tvalid_o && !m_axis_tlast_o))
    else $error("request taken while a frame is still in flight");

  a_load_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> m_axis_tvalid_o)
    else $error("accepted request produced no output");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import acfb_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailWait   = 30;

  localparam logic [1:0] OpUnused  = 2'd3;
  localparam logic [2:0] ModeBadLo = 3'd6;
  localparam logic [2:0] ModeBadHi = 3'd7;

  // lookup tables, entry 0 in the low bits
  localparam logic [17:0] ModeLongTbl  = {3'd6, 3'd4, 3'd2, 3'd0, 3'd1, 3'd1};
  localparam logic [17:0] ModeShortTbl = {3'd4, 3'd3, 3'd2, 3'd0, 3'd1, 3'd0};
  localparam logic [11:0] FanTbl       = {3'd1, 3'd2, 3'd3, 3'd5};
  localparam logic [29:0] ToggleBtnTbl = {5'h0B, 5'h07, 5'h08, 5'h08, 5'h02, 5'h05};
  localparam logic [15:0] VaneTbl      = {4'hA, 4'h3, 4'h2, 4'h1};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } frame_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [1:0]  s_axis_tuser_i;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [5:0]  cfg_data_i;

  frame_byte_t frame_bytes_q[$];
  logic [5:0]  lim_min = 6'd16;
  logic [5:0]  lim_max = 6'd30;

  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_now = 1'b0;

  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned requests = 0;
  int unsigned bytes_seen = 0;
  int unsigned err_replies = 0;
  int unsigned limit_writes = 0;

  ac_ir_frame_builder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic void predict_frame(input req_t r);
    logic [7:0]  fb [0:MaxFrameBytes-1];
    logic [2:0]  md;
    logic [2:0]  sh;
    logic [2:0]  fc;
    logic [2:0]  f2;
    logic [3:0]  sv;
    logic [3:0]  tnib;
    logic [4:0]  button;
    logic [5:0]  t;
    logic [7:0]  ck;
    logic        power;
    logic        bad;
    int          len;
    int          head_len;
    int          i;
    frame_byte_t fbyte;

    power  = 1'b1;
    bad    = 1'b0;
    sv     = r.feature_flags[1] ? VaneSwing : 4'h0;
    sh     = HorizAuto;
    button = BtnState;
    case (r.op)
      OpState: begin
        bad = (r.mode == ModeOff) || (r.mode > ModeFan);
      end
      OpToggle: begin
        bad = r.toggle_sel > SelMax;
        power = r.toggle_sel != 3'd0;
        if (!bad) button = ToggleBtnTbl[r.toggle_sel*5 +: 5];
      end
      OpExtra: begin
        bad = r.extra_sel > SelMax;
        if (r.extra_sel <= SelVaneHi) begin
          sv = VaneTbl[r.extra_sel[1:0]*4 +: 4];
          button = BtnVane;
        end else begin
          sh = (r.extra_sel == SelHAuto) ? HorizAuto : HorizMid;
          button = BtnSwingH;
        end
      end
      default: bad = 1'b1;
    endcase

    if (bad) begin
      fbyte = '{data: 8'h00, last: 1'b1, err: 1'b1};
      frame_bytes_q.push_back(fbyte);
      return;
    end

    md = ((r.mode == ModeOff) || (r.mode > ModeFan)) ? ModeCool : r.mode;
    t = r.temperature;
    if (t < lim_min) t = lim_min;
    if (t > lim_max) t = lim_max;
    tnib = 4'(t - lim_min);
    fc = FanTbl[r.fan*3 +: 3];
    for (i = 0; i < MaxFrameBytes; i++) fb[i] = 8'h00;

    if (r.model == ModelShort9) begin
      len = 9;
      head_len = 8;
      fb[0] = HdrShort;
      fb[1] = {tnib, 3'b000, power};
      fb[2] = {(sv != 4'h0) ? 2'b11 : 2'b00, 6'b100000};
      fb[4] = {2'b00, r.feature_flags[4], ShortCtl};
      fb[5] = {r.fan, 6'b0};
      fb[6] = {ModeShortTbl[md*3 +: 3], 5'b0};
      fb[7] = {1'b0, r.feature_flags[5], 6'b0};
    end else begin
      len = 14;
      head_len = 13;
      fb[0]  = HdrLong;
      fb[1]  = {tnib, sv};
      fb[2]  = {sh, 5'b0};
      fb[3]  = {6'b0, r.feature_flags[4], 1'b0};
      fb[4]  = {1'b0, power, 6'b0};
      fb[5]  = {fc, 5'b0};
      fb[6]  = {r.feature_flags[3], r.feature_flags[2], 6'b0};
      fb[7]  = {ModeLongTbl[md*3 +: 3], 5'b0};
      fb[8]  = {r.feature_flags[5], 7'b0};
      fb[12] = {3'b0, button};
    end
    ck = 8'h00;
    for (i = 0; i < head_len; i++) ck = ck + fb[i];
    fb[head_len] = ck;

    if (r.model == ModelLong20 || r.model == ModelLong22) begin
      f2 = (fc == 3'd5) ? 3'd0 : fc;
      if (r.model == ModelLong20) begin
        len = 20;
        fb[14] = HdrTail20;
        fb[16] = {f2, 5'b0};
      end else begin
        len = 22;
        fb[14] = HdrTail22;
        fb[16] = {f2[1:0], 6'b0};
      end
      ck = 8'h00;
      for (i = 14; i < len - 1; i++) ck = ck + fb[i];
      fb[len-1] = ck;
    end

    for (i = 0; i < len; i++) begin
      fbyte = '{data: fb[i], last: (i == len - 1), err: 1'b0};
      frame_bytes_q.push_back(fbyte);
    end
  endfunction

  function automatic void check_byte();
    frame_byte_t want;

    if (frame_bytes_q.size() == 0) begin
      $error("unexpected item: byte 0x%02h last %0b error %0b",
             m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      fail_count++;
      return;
    end
    want = frame_bytes_q.pop_front();
    bytes_seen++;
    if (want.err) err_replies++;
    if (m_axis_tdata_o !== want.data) begin
      $error("frame_byte: expected 0x%02h, got 0x%02h", want.data, m_axis_tdata_o);
      fail_count++;
    end
    if (m_axis_tlast_o !== want.last) begin
      $error("last_byte: expected %0b, got %0b", want.last, m_axis_tlast_o);
      fail_count++;
    end
    if (m_axis_tuser_o !== want.err) begin
      $error("error: expected %0b, got %0b", want.err, m_axis_tuser_o);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgTempMin) lim_min = cfg_data_i;
      else lim_max = cfg_data_i;
      limit_writes++;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predict_frame(req_t'({s_axis_tdata_i[24:0], s_axis_tuser_i}));
      requests++;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) check_byte();
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("watchdog: nothing moved for %0d cycles, %0d bytes outstanding",
             StallLimit, frame_bytes_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(input req_t r);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.op;
    s_axis_tdata_i  <= {7'b0, r[26:2]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [5:0] lo, input logic [5:0] hi);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgTempMin;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgTempMax;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t make_req(input logic [1:0] op, input logic [1:0] model,
                                    input logic [2:0] mode, input logic [1:0] fan,
                                    input logic [5:0] temp, input logic [5:0] flags,
                                    input logic [2:0] tsel, input logic [2:0] esel);
    req_t r;

    r.op            = op;
    r.model         = model;
    r.mode          = mode;
    r.fan           = fan;
    r.temperature   = temp;
    r.feature_flags = flags;
    r.toggle_sel    = tsel;
    r.extra_sel     = esel;
    return r;
  endfunction

  // mostly well-formed requests, about one in ten fully random
  function automatic req_t random_request();
    req_t r;

    r = req_t'(27'($urandom));
    if ($urandom_range(0, 9) != 0) begin
      r.op = 2'($urandom_range(0, 2));
      if (r.op == OpState) r.mode = 3'($urandom_range(1, 5));
      r.toggle_sel = 3'($urandom_range(0, 5));
      r.extra_sel  = 3'($urandom_range(0, 5));
      if (lim_min <= lim_max && $urandom_range(0, 1) == 1)
        r.temperature = 6'($urandom_range(lim_max, lim_min));
    end
    return r;
  endfunction

  task automatic test_directed();
    int s;

    for (s = 1; s <= 5; s++)
      send_request(make_req(OpState, 2'(s), 3'(s), 2'(s), s[0] ? 6'd63 : 6'd0,
                            s[0] ? 6'h3F : 6'h00, 3'd0, 3'd0));
    send_request(make_req(OpState, ModelLong22, ModeOff, 2'd3, 6'd20, 6'h3F, 3'd0, 3'd0));
    send_request(make_req(OpState, ModelShort9, ModeBadLo, 2'd0, 6'd20, 6'h00, 3'd7, 3'd7));
    send_request(make_req(OpState, ModelLong14, ModeBadHi, 2'd1, 6'd20, 6'h15, 3'd0, 3'd0));
    for (s = 0; s < 8; s++)
      send_request(make_req(OpToggle, 2'(s), 3'(s), 2'(s + 1), 6'(s * 9), 6'(~(s * 5)),
                            3'(s), 3'(7 - s)));
    for (s = 0; s < 8; s++)
      send_request(make_req(OpExtra, 2'(s + 2), 3'(7 - s), 2'(s), 6'(60 - s * 7),
                            6'(s * 11), 3'(7 - s), 3'(s)));
    send_request(make_req(OpUnused, ModelLong22, ModeHeat, 2'd2, 6'd25, 6'h2A, 3'd1, 3'd1));
  endtask

  task automatic limit_phase(input logic [5:0] lo, input logic [5:0] hi);
    set_limits(lo, hi);
    repeat (40) send_request(random_request());
  endtask

  task automatic test_limits();
    limit_phase(6'd0, 6'd63);
    limit_phase(6'd63, 6'd0);
    limit_phase(6'd20, 6'd25);
    limit_phase(6'd63, 6'd63);
    limit_phase(6'd0, 6'd0);
    limit_phase(6'd16, 6'd30);
  endtask

  task automatic test_backpressure();
    drain();
    tx_gaps  = 1'b0;
    hold_now = 1'b1;
    repeat (10) send_request(random_request());
    drain();
    tx_gaps = 1'b1;
  endtask

  task automatic test_back_to_back();
    drain();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (40) send_request(random_request());
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = '0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgTempMin;
    cfg_data_i      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_limits();
    test_backpressure();
    test_back_to_back();

    drain();
    repeat (TailWait) @(posedge clk_i);
    if (frame_bytes_q.size() != 0) begin
      $error("%0d expected bytes never arrived", frame_bytes_q.size());
      fail_count++;
    end
    $display("covered %0d requests over all ops, frame formats and error cases",
             requests);
    $display("%0d bytes checked, %0d error replies, %0d limit register writes",
             bytes_seen, err_replies, limit_writes);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
